[hw/rtl/rpap_pkg.sv]
package rpap_pkg;

   // Field widths of the channels.
   localparam int COORD_W = 31;
   localparam int HEAD_W  = 21;

   // The object-to-pivot offset is exact in 32 bits.
   localparam int OFS_W = 32;

   // Angles are carried as Q2.30 radians.
   localparam int ANG_Q = 30;

   // The datapath of the rotation cells is 64 bits wide, and the angle is 34 bits wide.
   localparam int XW = 64;
   localparam int ZW = 34;

   // Defaults for the top-level parameters.
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int FRAC_BITS_DEF    = 16;

   // Angle constants in Q2.30, and the reciprocal of the limit CORDIC gain.
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [29:0] GAIN_Q30    = 30'h26DD3B6A;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [HEAD_W-1:0]  head_type;
   typedef logic signed [OFS_W-1:0]   ofs_type;

   // Payload of the angle reduction cells, apart from the residue itself.
   typedef struct packed {
      ofs_type   dx;
      ofs_type   dy;
      coord_type px;
      coord_type py;
   } offset_type;

   // Payload of the rotation cells.
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      coord_type            px;
      coord_type            py;
   } rot_type;

   // Arctangent of 2^-idx in Q2.30, truncated.
   function automatic logic [ZW-1:0] atan_q30(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'h3243F6A8;
         1:  val = 32'h1DAC6705;
         2:  val = 32'h0FADBAFC;
         3:  val = 32'h07F56EA6;
         4:  val = 32'h03FEAB76;
         5:  val = 32'h01FFD55B;
         6:  val = 32'h00FFFAAA;
         7:  val = 32'h007FFF55;
         8:  val = 32'h003FFFEA;
         9:  val = 32'h001FFFFD;
         10: val = 32'h000FFFFF;
         11: val = 32'h0007FFFF;
         12: val = 32'h0003FFFF;
         13: val = 32'h0001FFFF;
         14: val = 32'h0000FFFF;
         15: val = 32'h00007FFF;
         16: val = 32'h00003FFF;
         17: val = 32'h00001FFF;
         18: val = 32'h00000FFF;
         19: val = 32'h000007FF;
         20: val = 32'h000003FF;
         21: val = 32'h000001FF;
         22: val = 32'h000000FF;
         23: val = 32'h0000007F;
         24: val = 32'h0000003F;
         25: val = 32'h0000001F;
         26: val = 32'h0000000F;
         27: val = 32'h00000008;
         28: val = 32'h00000004;
         29: val = 32'h00000002;
         30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return ZW'(val);
   endfunction

endpackage

[hw/rtl/rpap_reduce_cell.sv]
module rpap_reduce_cell #(
   parameter int RW    = 38,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 in_valid,
   input  rpap_pkg::offset_type in_ofs,
   input  logic [RW-1:0]        in_res,
   output logic                 out_valid,
   output rpap_pkg::offset_type out_ofs,
   output logic [RW-1:0]        out_res
);
   import rpap_pkg::*;

   // The multiple of a full turn that this cell may remove.
   localparam logic [RW-1:0] STEP = RW'(TWO_PI_Q30) << SHIFT;

   logic             valid_ff;
   offset_type       ofs_ff;
   logic [RW-1:0]    res_ff;
   logic [RW-1:0]    res_in;

   // One restoring step: remove the multiple when the residue is at least as large.
   assign res_in = (in_res >= STEP) ? (in_res - STEP) : in_res;

   // The valid flag moves whenever the cell is allowed to load.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // The payload is captured only for a real beat.
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         ofs_ff <= in_ofs;
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ofs   = ofs_ff;
   assign out_res   = res_ff;

endmodule

[hw/rtl/rpap_cordic_cell.sv]
module rpap_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  rpap_pkg::rot_type in_rot,
   output logic              out_valid,
   output rpap_pkg::rot_type out_rot
);
   import rpap_pkg::*;

   logic                 valid_ff;
   rot_type              rot_ff;
   rot_type              rot_in;
   logic signed [XW-1:0] x_cur;
   logic signed [XW-1:0] y_cur;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] z_cur;
   logic signed [ZW-1:0] step;

   assign x_cur = in_rot.x;
   assign y_cur = in_rot.y;
   assign z_cur = in_rot.z;
   assign xs    = x_cur >>> IDX;
   assign ys    = y_cur >>> IDX;
   assign step  = $signed(atan_q30(IDX));

   // One micro-rotation, with the direction taken from the sign of the remaining angle.
   always_comb begin
      rot_in = in_rot;
      if (!z_cur[ZW-1]) begin
         rot_in.x = x_cur - ys;
         rot_in.y = y_cur + xs;
         rot_in.z = z_cur - step;
      end else begin
         rot_in.x = x_cur + ys;
         rot_in.y = y_cur - xs;
         rot_in.z = z_cur + step;
      end
   end

   // The valid flag moves whenever the cell is allowed to load.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // The payload is captured only for a real beat.
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         rot_ff <= rot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;

endmodule

[hw/rtl/rotate_point_about_pivot_core.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  obj_x, obj_y, pivot_x, pivot_y, heading_before/after
// rsp       out        rsp_valid/rsp_stall  rotated_x, rotated_y, clipped
//
// A new beat can be taken on every cycle in which req_stall is low. The number of angle
// reduction cells is RED = max(20 - FRAC_BITS, 1) + 1. Each beat passes the input stage, the
// row of reduction cells, the prepare stage, the row of CORDIC cells and the output stage,
// one register each. A synchronous reset empties every stage, and the block holds no other state.
// A stall on rsp is taken up by the empty stages, one per cycle, before req is stalled.
module rotate_point_about_pivot_core #(
   parameter int CORDIC_STEPS = rpap_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = rpap_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rpap_pkg::coord_type req_obj_x,
   input  rpap_pkg::coord_type req_obj_y,
   input  rpap_pkg::coord_type req_pivot_x,
   input  rpap_pkg::coord_type req_pivot_y,
   input  rpap_pkg::head_type  req_heading_before,
   input  rpap_pkg::head_type  req_heading_after,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rpap_pkg::coord_type rsp_rotated_x,
   output rpap_pkg::coord_type rsp_rotated_y,
   output logic                rsp_clipped
);
   import rpap_pkg::*;

   // Angle difference in Q2.30: its width, the reduction width and the number of cells.
   localparam int ANG_SHIFT = ANG_Q - FRAC_BITS;
   localparam int AW        = HEAD_W + 1 + ANG_SHIFT;
   localparam int RW        = ((AW > 34) ? AW : 34) + 4;
   localparam int RED_TOP   = (AW > 32) ? (AW - 32) : 1;
   localparam int NRED      = RED_TOP + 1;

   // Stage numbering: input, reduction cells, prepare, CORDIC cells, output.
   localparam int ST_PREP  = NRED + 1;
   localparam int ST_CORD0 = NRED + 2;
   localparam int NST      = NRED + CORDIC_STEPS + 3;
   localparam int ST_OUT   = NST - 1;

   // The bias shifts the angle plus pi to a non-negative value with no effect on the residue.
   localparam logic [RW-1:0] BIAS = RW'(PI_Q30) + (RW'(TWO_PI_Q30) << RED_TOP);

   localparam logic [32:0] UPPER = 33'(PI_Q30) + 33'(HALF_PI_Q30);
   localparam logic [32:0] LOWER = 33'(PI_Q30) - 33'(HALF_PI_Q30);

   localparam int SW = XW - ANG_Q + 1;

   localparam logic signed [ZW-1:0] HALF_S = $signed(ZW'(HALF_PI_Q30));
   localparam logic signed [ZW-1:0] PI_S   = $signed(ZW'(PI_Q30));
   localparam logic signed [XW-1:0] ROUND  = XW'(64'd1 << (ANG_Q - 1));
   localparam logic signed [30:0]   GAIN_S = $signed({1'b0, GAIN_Q30});

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic [NST-1:0] valid;
   logic [NST-1:0] rdy;

   // A stage loads when it is empty or when its content moves on in the same cycle.
   assign rdy[ST_OUT] = !valid[ST_OUT] || !rsp_stall;
   genvar gk;
   generate
      for (gk = 0; gk < NST - 1; gk++) begin : g_rdy
         assign rdy[gk] = !valid[gk] || rdy[gk + 1];
      end
   endgenerate

   assign req_stall = !rdy[0];

   // Input stage: form the offset and the biased angle difference.
   logic                     in_valid_ff;
   offset_type               in_ofs_ff;
   offset_type               in_ofs_in;
   logic [RW-1:0]            in_res_ff;
   logic [RW-1:0]            in_res_in;
   logic signed [HEAD_W:0]   head_diff;
   logic signed [RW-1:0]     ang_sh;

   assign head_diff = (HEAD_W + 1)'(req_heading_before) - (HEAD_W + 1)'(req_heading_after);
   assign ang_sh    = RW'(head_diff) <<< ANG_SHIFT;
   assign in_res_in = $unsigned(ang_sh) + BIAS;

   always_comb begin
      in_ofs_in.dx = OFS_W'(req_obj_x) - OFS_W'(req_pivot_x);
      in_ofs_in.dy = OFS_W'(req_obj_y) - OFS_W'(req_pivot_y);
      in_ofs_in.px = req_pivot_x;
      in_ofs_in.py = req_pivot_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (rdy[0]) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && req_valid) begin
         in_ofs_ff <= in_ofs_in;
         in_res_ff <= in_res_in;
      end
   end

   assign valid[0] = in_valid_ff;

   // Reduction row: the cells remove multiples of a full turn, largest first.
   offset_type    red_ofs [NRED+1];
   logic [RW-1:0] red_res [NRED+1];

   assign red_ofs[0] = in_ofs_ff;
   assign red_res[0] = in_res_ff;

   generate
      for (gk = 0; gk < NRED; gk++) begin : g_red
         rpap_reduce_cell #(
            .RW    (RW),
            .SHIFT (RED_TOP - gk)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (rdy[gk + 1]),
            .in_valid  (valid[gk]),
            .in_ofs    (red_ofs[gk]),
            .in_res    (red_res[gk]),
            .out_valid (valid[gk + 1]),
            .out_ofs   (red_ofs[gk + 1]),
            .out_res   (red_res[gk + 1])
         );
      end
   endgenerate

   // Prepare stage: recentre the angle, take out a quarter turn and apply the gain.
   logic                 prep_valid_ff;
   rot_type              prep_ff;
   rot_type              prep_in;
   logic [32:0]          red_r;
   logic signed [ZW-1:0] z_mid;
   ofs_type              xq;
   ofs_type              yq;
   logic signed [62:0]   prod_x;
   logic signed [62:0]   prod_y;
   offset_type           red_last;

   assign red_last = red_ofs[NRED];
   assign red_r    = red_res[NRED][32:0];
   assign z_mid    = $signed(ZW'(red_r)) - PI_S;

   always_comb begin
      if (red_r > UPPER) begin
         xq         = -red_last.dy;
         yq         = red_last.dx;
         prep_in.z  = z_mid - HALF_S;
      end else if (red_r < LOWER) begin
         xq         = red_last.dy;
         yq         = -red_last.dx;
         prep_in.z  = z_mid + HALF_S;
      end else begin
         xq         = red_last.dx;
         yq         = red_last.dy;
         prep_in.z  = z_mid;
      end
      prep_in.x  = XW'(prod_x);
      prep_in.y  = XW'(prod_y);
      prep_in.px = red_last.px;
      prep_in.py = red_last.py;
   end

   assign prod_x = xq * GAIN_S;
   assign prod_y = yq * GAIN_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (rdy[ST_PREP]) begin
         prep_valid_ff <= valid[ST_PREP - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_PREP] && valid[ST_PREP - 1]) begin
         prep_ff <= prep_in;
      end
   end

   assign valid[ST_PREP] = prep_valid_ff;

   // CORDIC row: one micro-rotation per cell.
   rot_type cord [CORDIC_STEPS+1];

   assign cord[0] = prep_ff;

   generate
      for (gk = 0; gk < CORDIC_STEPS; gk++) begin : g_cord
         rpap_cordic_cell #(
            .IDX (gk)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (rdy[ST_CORD0 + gk]),
            .in_valid  (valid[ST_CORD0 + gk - 1]),
            .in_rot    (cord[gk]),
            .out_valid (valid[ST_CORD0 + gk]),
            .out_rot   (cord[gk + 1])
         );
      end
   endgenerate

   // Output stage: round to the coordinate grid, add the pivot back and saturate.
   logic                 out_valid_ff;
   coord_type            rx_ff;
   coord_type            ry_ff;
   logic                 clip_ff;
   coord_type            rx_in;
   coord_type            ry_in;
   rot_type              cord_last;
   logic signed [XW-1:0] x_rnd;
   logic signed [XW-1:0] y_rnd;
   logic signed [SW-1:0] x_sum;
   logic signed [SW-1:0] y_sum;
   logic                 x_hi;
   logic                 x_lo;
   logic                 y_hi;
   logic                 y_lo;

   assign cord_last = cord[CORDIC_STEPS];
   assign x_rnd     = cord_last.x + ROUND;
   assign y_rnd     = cord_last.y + ROUND;
   assign x_sum     = SW'($signed(x_rnd[XW-1:ANG_Q])) + SW'(cord_last.px);
   assign y_sum     = SW'($signed(y_rnd[XW-1:ANG_Q])) + SW'(cord_last.py);

   assign x_hi = !x_sum[SW-1] && (|x_sum[SW-2:COORD_W-1]);
   assign x_lo = x_sum[SW-1] && !(&x_sum[SW-2:COORD_W-1]);
   assign y_hi = !y_sum[SW-1] && (|y_sum[SW-2:COORD_W-1]);
   assign y_lo = y_sum[SW-1] && !(&y_sum[SW-2:COORD_W-1]);

   always_comb begin
      if (x_hi) begin
         rx_in = COORD_MAX;
      end else if (x_lo) begin
         rx_in = COORD_MIN;
      end else begin
         rx_in = x_sum[COORD_W-1:0];
      end
      if (y_hi) begin
         ry_in = COORD_MAX;
      end else if (y_lo) begin
         ry_in = COORD_MIN;
      end else begin
         ry_in = y_sum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy[ST_OUT]) begin
         out_valid_ff <= valid[ST_OUT - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT] && valid[ST_OUT - 1]) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         clip_ff <= x_hi || x_lo || y_hi || y_lo;
      end
   end

   assign valid[ST_OUT] = out_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_rotated_x = rx_ff;
   assign rsp_rotated_y = ry_ff;
   assign rsp_clipped   = clip_ff;

`ifndef SYNTHESIS
   // The input is only held off when every stage is full and the output is stalled.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid) && rsp_stall))
      else $error("req stalled while the pipeline has room");

   // Reset empties the whole row.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid == '0))
      else $error("stage still valid after reset");

   // After the last reduction cell, the residue lies within one full turn.
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      valid[NRED] |-> (red_res[NRED] < RW'(TWO_PI_Q30)))
      else $error("angle residue not reduced below a full turn");

   // The angle entering the CORDIC row lies within a quarter turn.
   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      valid[ST_PREP] |-> ((prep_ff.z <= HALF_S) && (prep_ff.z >= -HALF_S)))
      else $error("CORDIC start angle beyond a quarter turn");

   // A clipped beat carries at least one coordinate at a limit.
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         ((rsp_rotated_x == COORD_MAX) || (rsp_rotated_x == COORD_MIN) ||
          (rsp_rotated_y == COORD_MAX) || (rsp_rotated_y == COORD_MIN)))
      else $error("clipped flag set on an unsaturated beat");
`endif

endmodule
